// ===== rtl/bms_pkg.sv =====
// Shared types, constants and helper functions for the boat motion step block.
// Used by bms_mul, bms_cordic, bms_wrap and boat_motion_step; depends on nothing.
package bms_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_ITERS = 16;
  localparam int CW           = 30;
  localparam int CSH          = CW - FRAC_BITS;

  // shared multiplier: 36 x 27 signed, product rounded back to FRAC_BITS
  localparam int MA_W = 36;
  localparam int MB_W = 27;
  localparam int MP_W = MA_W + MB_W;
  localparam int MR_W = MP_W + 1 - FRAC_BITS;
  localparam logic [MP_W:0] RND_HALF =
    {{(MP_W - FRAC_BITS + 1){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

  localparam int ANG_W = 20;
  localparam int CZ_W  = 36;
  localparam int CORD_CW = $clog2(CORDIC_ITERS);

  localparam logic signed [CZ_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [CZ_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [CZ_W-1:0] CORDIC_K    = 36'sd652032874;

  localparam longint PI_FL = (64'sd3373259426 + (64'sd1 <<< (CSH - 1))) >>> CSH;
  localparam logic signed [ANG_W-1:0] PI_F = ANG_W'(PI_FL);

  localparam int WRAP_STEPS = 14;
  localparam int WRAP_W     = 38;
  localparam int WRAP_CW    = $clog2(WRAP_STEPS);
  localparam logic signed [WRAP_W-1:0] PI_W     = WRAP_W'(PI_F);
  localparam logic signed [WRAP_W-1:0] TWO_PI_W = PI_W <<< 1;
  localparam logic signed [WRAP_W-1:0] SPAN0    = TWO_PI_W <<< (WRAP_STEPS - 1);

  localparam int ONE_F       = 1 << FRAC_BITS;
  localparam int THR_SCALE   = ((3 << FRAC_BITS) + 5) / 10;
  localparam int STEER_SCALE = ((4 << FRAC_BITS) + 5) / 10;

  localparam logic signed [48:0] P40_HI = 49'sd549755813887;
  localparam logic signed [48:0] P40_LO = -P40_HI - 49'sd1;
  localparam logic signed [48:0] P24_HI = 49'sd8388607;
  localparam logic signed [48:0] P24_LO = -P24_HI - 49'sd1;

  typedef struct packed {
    logic go;
    logic acc;
  } mul_req_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  typedef enum logic [1:0] {
    K_MUL,
    K_CORD,
    K_WRAP
  } kind_t;

  typedef enum logic [4:0] {
    OP_THR, OP_STR,
    OP_DX, OP_DY,
    OP_CS_OLD, OP_PX, OP_PY,
    OP_CS_STR, OP_T1, OP_T2, OP_T3,
    OP_WH, OP_WD,
    OP_D1, OP_D2,
    OP_CS_NEW, OP_TH, OP_UX1, OP_UX2, OP_UY1, OP_UY2,
    OP_VX, OP_VY
  } op_t;

  typedef enum logic [2:0] {
    CFG_START_X, CFG_START_Y, CFG_DRAG, CFG_THRUST, CFG_ROT, CFG_STEP
  } cfg_idx_t;

  function automatic kind_t op_kind(input op_t op);
    kind_t k;
    unique case (op)
      OP_CS_OLD, OP_CS_STR, OP_CS_NEW: k = K_CORD;
      OP_WH, OP_WD:                    k = K_WRAP;
      default:                         k = K_MUL;
    endcase
    return k;
  endfunction

  // arctangent of 2^-i in Q2.30
  function automatic logic signed [CZ_W-1:0] atan_q30(input int unsigned i);
    logic signed [CZ_W-1:0] v;
    unique case (i)
      0:  v = 36'sd843314856;
      1:  v = 36'sd497837829;
      2:  v = 36'sd263043836;
      3:  v = 36'sd133525158;
      4:  v = 36'sd67021686;
      5:  v = 36'sd33543515;
      6:  v = 36'sd16775850;
      7:  v = 36'sd8388437;
      8:  v = 36'sd4194282;
      9:  v = 36'sd2097149;
      10: v = 36'sd1048575;
      11: v = 36'sd524287;
      12: v = 36'sd262143;
      13: v = 36'sd131071;
      14: v = 36'sd65535;
      15: v = 36'sd32767;
      16: v = 36'sd16383;
      17: v = 36'sd8191;
      18: v = 36'sd4095;
      19: v = 36'sd2047;
      20: v = 36'sd1023;
      21: v = 36'sd511;
      22: v = 36'sd255;
      default: v = 36'sd127;
    endcase
    return v;
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [48:0] v);
    logic signed [39:0] r;
    if (v > P40_HI) r = 40'sh7f_ffff_ffff;
    else if (v < P40_LO) r = 40'sh80_0000_0000;
    else r = v[39:0];
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [48:0] v);
    logic signed [23:0] r;
    if (v > P24_HI) r = 24'sh7f_ffff;
    else if (v < P24_LO) r = 24'sh80_0000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

// ===== rtl/bms_mul.sv =====
// Shared signed multiplier with round-half-up back to FRAC_BITS fraction bits.
// Optional accumulate adds the previous raw product before rounding. Uses bms_pkg.
module bms_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  bms_pkg::mul_req_t                   req,
  input  logic signed [bms_pkg::MA_W-1:0]     a,
  input  logic signed [bms_pkg::MB_W-1:0]     b,
  output logic                                done,
  output logic signed [bms_pkg::MR_W-1:0]     res
);

  logic signed [bms_pkg::MP_W-1:0] prod;
  logic signed [bms_pkg::MP_W-1:0] hold;
  logic                            stage;
  logic                            acc_q;
  logic [bms_pkg::MP_W:0]          sum;

  always_comb begin
    sum = {prod[bms_pkg::MP_W-1], prod}
        + (acc_q ? {hold[bms_pkg::MP_W-1], hold} : '0)
        + bms_pkg::RND_HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= 1'b0;
      done  <= 1'b0;
    end else begin
      stage <= req.go;
      done  <= stage;
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      prod  <= a * b;
      acc_q <= req.acc;
    end
    if (stage) begin
      hold <= prod;
      res  <= sum[bms_pkg::FRAC_BITS +: bms_pkg::MR_W];
    end
  end

endmodule

// ===== rtl/bms_cordic.sv =====
// Rotation-mode CORDIC in Q2.30, one micro-rotation per cycle, giving sin and cos
// of a Q3.16 angle rounded to Q.16. Uses bms_pkg.
module bms_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                go,
  input  logic signed [bms_pkg::ANG_W-1:0]    ang,
  output logic                                done,
  output logic signed [bms_pkg::ANG_W-1:0]    cos_q,
  output logic signed [bms_pkg::ANG_W-1:0]    sin_q
);

  logic signed [bms_pkg::CZ_W-1:0] x, y, z;
  logic signed [bms_pkg::CZ_W-1:0] zin, xs, ys, xf, yf, xr, yr;
  logic                            flip, busy, fin;
  logic [bms_pkg::CORD_CW-1:0]     it;

  always_comb begin
    zin = {{(bms_pkg::CZ_W - bms_pkg::ANG_W - bms_pkg::CSH){ang[bms_pkg::ANG_W-1]}},
           ang, {bms_pkg::CSH{1'b0}}};
    xs  = x >>> it;
    ys  = y >>> it;
    xf  = flip ? -x : x;
    yf  = flip ? -y : y;
    xr  = xf + (36'sd1 <<< (bms_pkg::CSH - 1));
    yr  = yf + (36'sd1 <<< (bms_pkg::CSH - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (go) begin
        busy <= 1'b1;
      end else if (busy && it == bms_pkg::CORD_CW'(bms_pkg::CORDIC_ITERS - 1)) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x  <= bms_pkg::CORDIC_K;
      y  <= '0;
      it <= '0;
      // fold the outer half turns onto the inner half and flip the result
      if (zin > bms_pkg::HALF_PI_Q30) begin
        z    <= zin - bms_pkg::PI_Q30;
        flip <= 1'b1;
      end else if (zin < -bms_pkg::HALF_PI_Q30) begin
        z    <= zin + bms_pkg::PI_Q30;
        flip <= 1'b1;
      end else begin
        z    <= zin;
        flip <= 1'b0;
      end
    end else if (busy) begin
      if (!z[bms_pkg::CZ_W-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - bms_pkg::atan_q30({{(32 - bms_pkg::CORD_CW){1'b0}}, it});
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + bms_pkg::atan_q30({{(32 - bms_pkg::CORD_CW){1'b0}}, it});
      end
      it <= it + 1'b1;
    end
    if (fin) begin
      cos_q <= xr[bms_pkg::CSH +: bms_pkg::ANG_W];
      sin_q <= yr[bms_pkg::CSH +: bms_pkg::ANG_W];
    end
  end

endmodule

// ===== rtl/bms_wrap.sv =====
// Angle wrap to [-pi, pi): floor modulo by 2*pi through a shift-and-subtract
// sequence, one multiple of 2*pi per cycle. Uses bms_pkg.
module bms_wrap (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                go,
  input  logic signed [bms_pkg::CZ_W-1:0]     val,
  output logic                                done,
  output logic signed [bms_pkg::ANG_W-1:0]    res
);

  logic signed [bms_pkg::WRAP_W-1:0] r, span, sub, add, rr;
  logic                              busy, fin;
  logic [bms_pkg::WRAP_CW-1:0]       k;

  always_comb begin
    sub = r - span;
    add = r + span;
    rr  = (r[bms_pkg::WRAP_W-1] ? r + bms_pkg::TWO_PI_W : r) - bms_pkg::PI_W;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (go) begin
        busy <= 1'b1;
      end else if (busy && k == '0) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      r    <= bms_pkg::WRAP_W'(val) + bms_pkg::PI_W;
      span <= bms_pkg::SPAN0;
      k    <= bms_pkg::WRAP_CW'(bms_pkg::WRAP_STEPS - 1);
    end else if (busy) begin
      // pull the value toward [-2pi, 2pi) from either side
      if (!r[bms_pkg::WRAP_W-1] && !sub[bms_pkg::WRAP_W-1]) begin
        r <= sub;
      end else if (r[bms_pkg::WRAP_W-1] && add[bms_pkg::WRAP_W-1]) begin
        r <= add;
      end
      span <= span >>> 1;
      k    <= k - 1'b1;
    end
    if (fin) begin
      res <= rr[bms_pkg::ANG_W-1:0];
    end
  end

endmodule

// ===== rtl/boat_motion_step.sv =====
// Boat plant model step. A command word (cmd = 0) clamps and stores throttle and
// steering and gives no result. A tick word (cmd = 1) updates position, heading
// and velocity and delivers one result word: 16 products through the single
// shared multiplier, three CORDIC runs and two angle wraps, done strictly in
// sequence. in_ready is high only while idle; a result waiting on out_ready
// does not block acceptance of the next word.
module boat_motion_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic signed [15:0] throttle_in,
  input  logic signed [15:0] steer_in,
  input  logic signed [23:0] current_vx,
  input  logic signed [23:0] current_vy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [39:0] pos_x,
  output logic signed [39:0] pos_y,
  output logic signed [18:0] heading_out,
  output logic signed [18:0] heading_step,
  output logic signed [24:0] ground_vx,
  output logic signed [24:0] ground_vy,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [39:0]        cfg_data
);

  bms_pkg::state_t state;
  bms_pkg::op_t    op;
  bms_pkg::kind_t  kind;
  logic            issued;

  logic signed [39:0] start_x, start_y, disp_x, disp_y;
  logic [23:0]        drag, thrust, rot;
  logic [15:0]        tstep;
  logic signed [23:0] vel_x, vel_y, cx, cy;
  logic signed [19:0] heading, head_old, steer_angle, hc, hs, ss, dh;
  logic [15:0]        throttle_held;
  logic [12:0]        thr_cl, thr_cl_next;
  logic signed [13:0] str_cl, str_cl_next;
  logic signed [47:0] tmp, thr, ux, uy;
  logic signed [26:0] fac, one_abs;

  bms_pkg::mul_req_t             mreq;
  logic signed [bms_pkg::MA_W-1:0] ma;
  logic signed [bms_pkg::MB_W-1:0] mb;
  logic                          mul_done, cord_go, cord_done, wrap_go, wrap_done;
  logic signed [bms_pkg::MR_W-1:0] mres;
  logic signed [19:0]            cang, ccos, csin, wres;
  logic signed [35:0]            wval;
  logic                          accept, fin_load;

  assign in_ready = (state == bms_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fin_load = (state == bms_pkg::S_FIN) && (!out_valid || out_ready);
  assign kind     = bms_pkg::op_kind(op);

  always_comb begin
    if (throttle_in < 16'sd0) thr_cl_next = '0;
    else if (throttle_in > 16'sd4096) thr_cl_next = 13'd4096;
    else thr_cl_next = throttle_in[12:0];
    if (steer_in < -16'sd4096) str_cl_next = -14'sd4096;
    else if (steer_in > 16'sd4096) str_cl_next = 14'sd4096;
    else str_cl_next = steer_in[13:0];
    one_abs = 27'(bms_pkg::ONE_F)
            + (steer_angle[19] ? -27'(steer_angle) : 27'(steer_angle));
  end

  // issue one unit operation per step, then wait for its done
  always_comb begin
    mreq.go  = (state == bms_pkg::S_RUN) && !issued && (kind == bms_pkg::K_MUL);
    mreq.acc = (op == bms_pkg::OP_PY);
    cord_go  = (state == bms_pkg::S_RUN) && !issued && (kind == bms_pkg::K_CORD);
    wrap_go  = (state == bms_pkg::S_RUN) && !issued && (kind == bms_pkg::K_WRAP);
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (op)
      bms_pkg::OP_THR: begin
        ma = {19'b0, thr_cl, 4'b0};
        mb = 27'(bms_pkg::THR_SCALE);
      end
      bms_pkg::OP_STR: begin
        ma = {{18{str_cl[13]}}, str_cl, 4'b0};
        mb = 27'(bms_pkg::STEER_SCALE);
      end
      bms_pkg::OP_DX: begin
        ma = 36'(25'(vel_x) + 25'(cx));
        mb = {11'b0, tstep};
      end
      bms_pkg::OP_DY: begin
        ma = 36'(25'(vel_y) + 25'(cy));
        mb = {11'b0, tstep};
      end
      bms_pkg::OP_PX: begin
        ma = 36'(vel_x);
        mb = 27'(hc);
      end
      bms_pkg::OP_PY: begin
        ma = 36'(vel_y);
        mb = 27'(hs);
      end
      bms_pkg::OP_T1: begin
        ma = tmp[35:0];
        mb = 27'(ss);
      end
      bms_pkg::OP_T2: begin
        ma = tmp[35:0];
        mb = {3'b0, rot};
      end
      bms_pkg::OP_T3, bms_pkg::OP_D2, bms_pkg::OP_UX2, bms_pkg::OP_UY2: begin
        ma = tmp[35:0];
        mb = {11'b0, tstep};
      end
      bms_pkg::OP_D1: begin
        ma = {12'b0, drag};
        mb = one_abs;
      end
      bms_pkg::OP_TH: begin
        ma = {12'b0, thrust};
        mb = {11'b0, throttle_held};
      end
      bms_pkg::OP_UX1: begin
        ma = thr[35:0];
        mb = 27'(hc);
      end
      bms_pkg::OP_UY1: begin
        ma = thr[35:0];
        mb = 27'(hs);
      end
      bms_pkg::OP_VX: begin
        ma = 36'(fac);
        mb = 27'(vel_x);
      end
      bms_pkg::OP_VY: begin
        ma = 36'(fac);
        mb = 27'(vel_y);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    unique case (op)
      bms_pkg::OP_CS_STR: cang = steer_angle;
      default:            cang = heading;
    endcase
    unique case (op)
      bms_pkg::OP_WD: wval = 36'(heading) - 36'(head_old);
      default:        wval = 36'(head_old) + 36'(tmp);
    endcase
  end

  bms_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .a    (ma),
    .b    (mb),
    .done (mul_done),
    .res  (mres)
  );

  bms_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .go    (cord_go),
    .ang   (cang),
    .done  (cord_done),
    .cos_q (ccos),
    .sin_q (csin)
  );

  bms_wrap u_wrap (
    .clk  (clk),
    .rst  (rst),
    .go   (wrap_go),
    .val  (wval),
    .done (wrap_done),
    .res  (wres)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bms_pkg::S_IDLE;
      op     <= bms_pkg::OP_THR;
      issued <= 1'b0;
    end else begin
      unique case (state)
        bms_pkg::S_IDLE: begin
          if (accept) begin
            state  <= bms_pkg::S_RUN;
            issued <= 1'b0;
            op     <= cmd ? bms_pkg::OP_DX : bms_pkg::OP_THR;
          end
        end
        bms_pkg::S_RUN: begin
          if (mreq.go || cord_go || wrap_go) begin
            issued <= 1'b1;
          end else if (mul_done || cord_done || wrap_done) begin
            issued <= 1'b0;
            if (op == bms_pkg::OP_STR) begin
              state <= bms_pkg::S_IDLE;
            end else if (op == bms_pkg::OP_VY) begin
              state <= bms_pkg::S_FIN;
            end else begin
              op <= bms_pkg::op_t'(op + 5'd1);
            end
          end
        end
        bms_pkg::S_FIN: begin
          if (fin_load) begin
            state <= bms_pkg::S_IDLE;
          end
        end
        default: state <= bms_pkg::S_IDLE;
      endcase
    end
  end

  // model state and write-back of unit results
  always_ff @(posedge clk) begin
    if (rst) begin
      disp_x        <= '0;
      disp_y        <= '0;
      vel_x         <= '0;
      vel_y         <= '0;
      heading       <= '0;
      throttle_held <= '0;
      steer_angle   <= '0;
    end else begin
      if (mul_done) begin
        unique case (op)
          bms_pkg::OP_THR: throttle_held <= mres[15:0];
          bms_pkg::OP_STR: steer_angle   <= mres[19:0];
          bms_pkg::OP_DX:  disp_x <= bms_pkg::sat40(49'(disp_x) + 49'(mres));
          bms_pkg::OP_DY:  disp_y <= bms_pkg::sat40(49'(disp_y) + 49'(mres));
          bms_pkg::OP_VX:  vel_x  <= bms_pkg::sat24(49'(mres) + 49'(ux));
          bms_pkg::OP_VY:  vel_y  <= bms_pkg::sat24(49'(mres) + 49'(uy));
          default: ;
        endcase
      end
      if (wrap_done && op == bms_pkg::OP_WH) begin
        heading <= wres;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      thr_cl   <= thr_cl_next;
      str_cl   <= str_cl_next;
      cx       <= current_vx;
      cy       <= current_vy;
      head_old <= heading;
    end
    if (mul_done) begin
      unique case (op)
        bms_pkg::OP_PY, bms_pkg::OP_T1, bms_pkg::OP_T2, bms_pkg::OP_T3,
        bms_pkg::OP_D1, bms_pkg::OP_UX1, bms_pkg::OP_UY1: tmp <= mres;
        bms_pkg::OP_D2:  fac <= 27'(bms_pkg::ONE_F) - mres[26:0];
        bms_pkg::OP_TH:  thr <= mres;
        bms_pkg::OP_UX2: ux  <= mres;
        bms_pkg::OP_UY2: uy  <= mres;
        default: ;
      endcase
    end
    if (cord_done) begin
      if (op == bms_pkg::OP_CS_STR) begin
        ss <= csin;
      end else begin
        hc <= ccos;
        hs <= csin;
      end
    end
    if (wrap_done && op == bms_pkg::OP_WD) begin
      dh <= wres;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
      drag    <= 24'd196608;
      thrust  <= 24'd6553600;
      rot     <= 24'd65536;
      tstep   <= 16'd2185;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bms_pkg::CFG_START_X: start_x <= cfg_data;
        bms_pkg::CFG_START_Y: start_y <= cfg_data;
        bms_pkg::CFG_DRAG:    drag    <= cfg_data[23:0];
        bms_pkg::CFG_THRUST:  thrust  <= cfg_data[23:0];
        bms_pkg::CFG_ROT:     rot     <= cfg_data[23:0];
        bms_pkg::CFG_STEP:    tstep   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      pos_x        <= bms_pkg::sat40(49'(start_x) + 49'(disp_x));
      pos_y        <= bms_pkg::sat40(49'(start_y) + 49'(disp_y));
      heading_out  <= heading[18:0];
      heading_step <= dh[18:0];
      ground_vx    <= 25'(vel_x) + 25'(cx);
      ground_vy    <= 25'(vel_y) + 25'(cy);
    end
  end

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    (mul_done || cord_done || wrap_done) |-> (state == bms_pkg::S_RUN && issued))
    else $error("unit done without an outstanding operation");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heading_out >= -19'sd205887 && heading_out <= 19'sd205886))
    else $error("heading outside [-pi, pi)");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd) |=> !in_ready)
    else $error("ready right after a tick word was taken");

endmodule
